### rtl/cpl_pkg.sv
// Shared constants and types for the cumulative path length block.
// No dependencies; imported by every module under rtl.
package cpl_pkg;

  localparam int FIELD_W        = 24;  // width of each coordinate port
  localparam int TOTAL_W        = 48;  // running total, signed Q36.12
  localparam int CFG_W          = 2;   // num_components register
  localparam int MAX_COMPONENTS = 3;
  localparam int COORD_BITS     = 24;

  localparam logic [CFG_W-1:0]   NUM_COMP_RESET = CFG_W'(3);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX      = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic [TOTAL_W-1:0] TOTAL_MIN      = {1'b1, {(TOTAL_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_MERGE,
    ST_LOAD,
    ST_ROOT,
    ST_ACCUM
  } cpl_state_e;

  // per-request strobes from the sequencer to every lane
  typedef struct packed {
    logic load;    // take new point, form difference to previous
    logic square;  // register squared magnitude of the difference
  } lane_ctrl_t;

endpackage

### rtl/cpl_lane.sv
// One coordinate lane: holds the previous coordinate, forms the difference
// and its square. Depends on cpl_pkg.
module cpl_lane #(
  parameter int COORD_BITS = cpl_pkg::COORD_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cpl_pkg::lane_ctrl_t                   ctrl_i,
  input  logic signed [cpl_pkg::FIELD_W-1:0]    coord_i,
  output logic signed [COORD_BITS:0]            diff_o,
  output logic        [2*COORD_BITS-1:0]        sq_o
);
  import cpl_pkg::*;

  localparam int RAW_W = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int DW    = COORD_BITS + 1;

  logic        [RAW_W-1:0]        raw;
  logic signed [COORD_BITS-1:0]   cur;
  logic signed [COORD_BITS-1:0]   prev_q;
  logic signed [DW-1:0]           diff_d, diff_q, neg;
  logic        [COORD_BITS-1:0]   mag;
  logic        [2*COORD_BITS-1:0] sq_d, sq_q;

  // field bits above COORD_BITS are dropped, missing ones read as zero
  assign raw    = RAW_W'($unsigned(coord_i));
  assign cur    = $signed(raw[COORD_BITS-1:0]);
  assign diff_d = $signed({cur[COORD_BITS-1], cur}) - $signed({prev_q[COORD_BITS-1], prev_q});
  assign neg    = -diff_q;
  // |diff| never exceeds 2^COORD_BITS - 1
  assign mag    = diff_q[DW-1] ? neg[COORD_BITS-1:0] : diff_q[COORD_BITS-1:0];
  assign sq_d   = {{COORD_BITS{1'b0}}, mag} * {{COORD_BITS{1'b0}}, mag};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (ctrl_i.load) begin
      prev_q <= cur;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      diff_q <= diff_d;
    end
    if (ctrl_i.square) begin
      sq_q <= sq_d;
    end
  end

  assign diff_o = diff_q;
  assign sq_o   = sq_q;

endmodule

### rtl/cpl_merge.sv
// Merge stage: registered sum of the squared differences of the lanes in use.
// Depends on cpl_pkg.
module cpl_merge #(
  parameter int NUM_LANES  = cpl_pkg::MAX_COMPONENTS,
  parameter int COORD_BITS = cpl_pkg::COORD_BITS
) (
  input  logic                          clk_i,
  input  logic                          load_i,
  input  logic [cpl_pkg::CFG_W-1:0]     lanes_used_i,
  input  logic [2*COORD_BITS-1:0]       sq_i [NUM_LANES],
  output logic [2*COORD_BITS+1:0]       sum_o
);
  import cpl_pkg::*;

  localparam int SUM_W = 2 * COORD_BITS + 2;

  logic [SUM_W-1:0] sum_d, sum_q;

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (i < int'(lanes_used_i)) begin
        sum_d = sum_d + SUM_W'(sq_i[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

### rtl/cpl_isqrt.sv
// Restoring digit-by-digit floor square root, one root bit per cycle.
// Depends on cpl_pkg.
module cpl_isqrt #(
  parameter int SUM_W = 2 * cpl_pkg::COORD_BITS + 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [SUM_W-1:0]     operand_i,
  output logic                 busy_o,
  output logic [SUM_W/2-1:0]   root_o
);
  import cpl_pkg::*;

  localparam int ROOT_W = SUM_W / 2;
  localparam int REM_W  = ROOT_W + 1;
  localparam int SH_W   = ROOT_W + 3;
  localparam int CNT_W  = $clog2(ROOT_W + 1);

  logic [SUM_W-1:0]  x_q, x_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SH_W-1:0]   rem_sh, trial, rem_sub;

  assign rem_sh  = {rem_q, x_q[SUM_W-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign rem_sub = rem_sh - trial;
  assign busy_o  = (cnt_q != '0);

  always_comb begin
    x_d    = x_q;
    root_d = root_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      x_d    = operand_i;
      root_d = '0;
      rem_d  = '0;
      cnt_d  = CNT_W'(ROOT_W);
    end else if (busy_o) begin
      x_d   = {x_q[SUM_W-3:0], 2'b00};
      cnt_d = cnt_q - 1'b1;
      if (rem_sh >= trial) begin
        rem_d  = rem_sub[REM_W-1:0];
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[REM_W-1:0];
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    root_q <= root_d;
    rem_q  <= rem_d;
  end

  assign root_o = root_q;

endmodule

### rtl/cumulative_path_length.sv
// Top level: running arc length of a point stream, one lane per component.
// Depends on cpl_pkg, cpl_lane, cpl_merge and cpl_isqrt.
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  input     | in_valid_i/in_ready_o, coord_*_i, restart_i | in
//  result    | out_valid_o/out_ready_i, path_length_o,    | out
//            | saturated_o                               |
//  config    | cfg_we_i, cfg_wdata_i (num_components)    | in
//
// A point with two or three components passes through the square, merge,
// load, root and accumulate states from acceptance to result; the root unit
// retires one bit per cycle. First points and single-component points go
// straight from idle to the accumulate state. A new request is taken
// once the previous one has been written to the output register, even while
// that result is unread; a result still unread holds the next one back.
// Reset clears the previous point, total, flags and sets num_components to 3.
module cumulative_path_length #(
  parameter int MAX_COMPONENTS = cpl_pkg::MAX_COMPONENTS,
  parameter int COORD_BITS     = cpl_pkg::COORD_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cpl_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [cpl_pkg::FIELD_W-1:0] coord_a_i,
  input  logic signed [cpl_pkg::FIELD_W-1:0] coord_b_i,
  input  logic signed [cpl_pkg::FIELD_W-1:0] coord_c_i,
  input  logic                               restart_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [cpl_pkg::TOTAL_W-1:0] path_length_o,
  output logic                               saturated_o
);
  import cpl_pkg::*;

  localparam int NUM_LANES = (MAX_COMPONENTS > 3) ? 3 : MAX_COMPONENTS;
  localparam int DW        = COORD_BITS + 1;
  localparam int SUM_W     = 2 * COORD_BITS + 2;
  localparam int ROOT_W    = SUM_W / 2;
  localparam int ACC_W     = TOTAL_W + 1;

  cpl_state_e state_q, state_d;
  lane_ctrl_t lane_ctrl;

  logic [CFG_W-1:0]         num_comp_q, lanes_used;
  logic                     accept, first_d, single_d;
  logic                     first_q, single_q, have_prev_q;
  logic                     merge_load, sqrt_start, sqrt_busy, accum_go;
  logic signed [FIELD_W-1:0] coord [3];
  logic signed [DW-1:0]     diff [NUM_LANES];
  logic [2*COORD_BITS-1:0]  sq [NUM_LANES];
  logic [SUM_W-1:0]         sum;
  logic [ROOT_W-1:0]        root;
  logic signed [ACC_W-1:0]  step, acc;
  logic [TOTAL_W-1:0]       total_q, total_d;
  logic                     sat_q, sat_d;
  logic                     out_valid_q;
  logic [TOTAL_W-1:0]       path_length_q;
  logic                     saturated_q;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_comp_q <= NUM_COMP_RESET;
    end else if (cfg_we_i) begin
      num_comp_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (num_comp_q == '0) begin
      lanes_used = CFG_W'(1);
    end else if (int'(num_comp_q) > NUM_LANES) begin
      lanes_used = CFG_W'(NUM_LANES);
    end else begin
      lanes_used = num_comp_q;
    end
  end

  // ---------------- lanes ----------------
  assign coord[0] = coord_a_i;
  assign coord[1] = coord_b_i;
  assign coord[2] = coord_c_i;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    cpl_lane #(
      .COORD_BITS(COORD_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (lane_ctrl),
      .coord_i(coord[g]),
      .diff_o (diff[g]),
      .sq_o   (sq[g])
    );
  end

  cpl_merge #(
    .NUM_LANES (NUM_LANES),
    .COORD_BITS(COORD_BITS)
  ) u_merge (
    .clk_i       (clk_i),
    .load_i      (merge_load),
    .lanes_used_i(lanes_used),
    .sq_i        (sq),
    .sum_o       (sum)
  );

  cpl_isqrt #(
    .SUM_W(SUM_W)
  ) u_isqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (sqrt_start),
    .operand_i(sum),
    .busy_o   (sqrt_busy),
    .root_o   (root)
  );

  // ---------------- sequencer ----------------
  assign accept   = in_valid_i && in_ready_o;
  assign first_d  = restart_i || !have_prev_q;
  assign single_d = (lanes_used == CFG_W'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (first_d || single_d) ? ST_ACCUM : ST_SQUARE;
        end
      end
      ST_SQUARE: state_d = ST_MERGE;
      ST_MERGE:  state_d = ST_LOAD;
      ST_LOAD:   state_d = ST_ROOT;
      ST_ROOT: begin
        if (!sqrt_busy) begin
          state_d = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = (state_q == ST_IDLE);
    lane_ctrl.load   = in_valid_i && (state_q == ST_IDLE);
    lane_ctrl.square = (state_q == ST_SQUARE);
    merge_load       = (state_q == ST_MERGE);
    sqrt_start       = (state_q == ST_LOAD);
    accum_go         = (state_q == ST_ACCUM) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      have_prev_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        have_prev_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      first_q  <= first_d;
      single_q <= single_d;
    end
  end

  // ---------------- accumulate with saturation ----------------
  assign step = single_q ? ACC_W'(diff[0]) : $signed(ACC_W'(root));
  assign acc  = $signed({total_q[TOTAL_W-1], total_q}) + step;

  always_comb begin
    total_d = acc[TOTAL_W-1:0];
    sat_d   = sat_q;
    if (first_q) begin
      total_d = '0;
      sat_d   = 1'b0;
    end else if (acc[ACC_W-1] != acc[ACC_W-2]) begin
      total_d = acc[ACC_W-1] ? TOTAL_MIN : TOTAL_MAX;
      sat_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accum_go) begin
        total_q     <= total_d;
        sat_q       <= sat_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accum_go) begin
      path_length_q <= total_d;
      saturated_q   <= sat_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign path_length_o = $signed(path_length_q);
  assign saturated_o   = saturated_q;

  // ---------------- assertions ----------------
  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  a_root_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_busy |-> state_q == ST_ROOT)
    else $error("root unit busy outside the root state");

  a_first_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accum_go && first_q |=> out_valid_o && path_length_o == '0 && !saturated_o)
    else $error("first point did not give a zero length");

  a_sat_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accum_go && !sat_q && sat_d |-> total_d == TOTAL_MAX || total_d == TOTAL_MIN)
    else $error("saturation flagged without a clamped total");

endmodule

### bench/cpl_tb_pkg.sv
// Scoreboard for the cumulative path length bench: tracks the point stream
// and running total on its own and checks each result. Depends on cpl_pkg.
`timescale 1ns / 100ps
package cpl_tb_pkg;

  import cpl_pkg::*;

  typedef logic signed [FIELD_W-1:0] coord_t;
  typedef logic signed [TOTAL_W-1:0] total_t;

  typedef struct {
    total_t length;
    logic   clamped;
  } arc_length_t;

  class path_length_scoreboard;
    coord_t        last_pt[3];
    total_t        total;
    bit            have_last;
    bit            clamped;
    logic [CFG_W-1:0] components;
    arc_length_t   awaited_lengths[$];
    int unsigned   mismatch_count;

    function new();
      for (int i = 0; i < 3; i++) last_pt[i] = '0;
      total          = '0;
      have_last      = 1'b0;
      clamped        = 1'b0;
      components     = NUM_COMP_RESET;
      mismatch_count = 0;
    endfunction

    function void set_components(logic [CFG_W-1:0] value);
      components = value;
    endfunction

    function int pending();
      return awaited_lengths.size();
    endfunction

    function void report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatch_count++;
    endfunction

    // floor square root, one result bit at a time from the top
    function longint unsigned floor_sqrt(longint unsigned value);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 25; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= value) root = trial;
      end
      return root;
    endfunction

    function void note_point(coord_t a, coord_t b, coord_t c, logic restart);
      coord_t          pt[3];
      int              n;
      longint          d;
      longint unsigned sq_sum;
      longint          step;
      longint          acc;
      longint          hi;
      longint          lo;
      arc_length_t     e;
      pt[0] = a;
      pt[1] = b;
      pt[2] = c;
      n = (components == 0) ? 1 : int'(components);
      if (n > MAX_COMPONENTS) n = MAX_COMPONENTS;
      if (restart || !have_last) begin
        total     = '0;
        clamped   = 1'b0;
        have_last = 1'b1;
      end else begin
        if (n == 1) begin
          // one component: signed difference, not its magnitude
          step = longint'(pt[0]) - longint'(last_pt[0]);
        end else begin
          sq_sum = 0;
          for (int i = 0; i < n; i++) begin
            d = longint'(pt[i]) - longint'(last_pt[i]);
            sq_sum += longint'(d * d);
          end
          step = longint'(floor_sqrt(sq_sum));
        end
        hi  = longint'($signed(TOTAL_MAX));
        lo  = longint'($signed(TOTAL_MIN));
        acc = longint'(total) + step;
        if (acc > hi) begin
          acc     = hi;
          clamped = 1'b1;
        end else if (acc < lo) begin
          acc     = lo;
          clamped = 1'b1;
        end
        total = total_t'(acc);
      end
      for (int i = 0; i < 3; i++) last_pt[i] = pt[i];
      e.length  = total;
      e.clamped = clamped;
      awaited_lengths.push_back(e);
    endfunction

    function void check_result(total_t length, logic sat);
      arc_length_t e;
      if (awaited_lengths.size() == 0) begin
        report_mismatch($sformatf("result %0d with no request outstanding", length));
        return;
      end
      e = awaited_lengths.pop_front();
      if (length !== e.length)
        report_mismatch($sformatf("path_length %0d, want %0d", length, e.length));
      if (sat !== e.clamped)
        report_mismatch($sformatf("saturated %b, want %b", sat, e.clamped));
    endfunction
  endclass

endpackage

### bench/tb_cumulative_path_length.sv
// Top of the cumulative path length bench: directed and random point streams
// with idle bursts on both channels. Depends on cpl_pkg, cpl_tb_pkg and the RTL.
`timescale 1ns / 100ps
module tb_cumulative_path_length;

  import cpl_pkg::*;
  import cpl_tb_pkg::*;

  localparam int     CYCLE_LIMIT   = 400000;
  localparam int     PHASE_ITEMS   = 250;
  localparam coord_t C_MAX         = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam coord_t C_MIN         = {1'b1, {(FIELD_W-1){1'b0}}};
  localparam coord_t C_ZERO        = '0;
  localparam coord_t C_NEG1        = '1;
  localparam coord_t C_ONE_UNIT    = coord_t'(1 << 12);  // 1.0 in Q12.12

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  coord_t           coord_a_i   = '0;
  coord_t           coord_b_i   = '0;
  coord_t           coord_c_i   = '0;
  logic             restart_i   = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  total_t           path_length_o;
  logic             saturated_o;

  path_length_scoreboard sb;
  int unsigned           cycle_count = 0;
  bit                    calm = 1'b0;   // no idling on either side
  coord_t                gen_pt[3];

  cumulative_path_length i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .coord_a_i     (coord_a_i),
    .coord_b_i     (coord_b_i),
    .coord_c_i     (coord_c_i),
    .restart_i     (restart_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .path_length_o (path_length_o),
    .saturated_o   (saturated_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // sample handshakes and register writes at the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.set_components(cfg_wdata_i);
      if (out_valid_o && out_ready_i) sb.check_result(path_length_o, saturated_o);
      if (in_valid_i && in_ready_o) sb.note_point(coord_a_i, coord_b_i, coord_c_i, restart_i);
    end
  end

  // result side back-pressure
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // leaves valid high; caller lowers it for a gap or at the end
  task automatic send_point(input coord_t a, input coord_t b, input coord_t c,
                            input logic rs);
    in_valid_i <= 1'b1;
    coord_a_i  <= a;
    coord_b_i  <= b;
    coord_c_i  <= c;
    restart_i  <= rs;
    gen_pt[0]  = a;
    gen_pt[1]  = b;
    gen_pt[2]  = c;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // one edge first so the sampler has logged the last accepted request
  task automatic wait_drained();
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [CFG_W-1:0] n);
    in_valid_i <= 1'b0;
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic coord_t pick_extreme();
    case ($urandom_range(0, 3))
      0:       return C_MAX;
      1:       return C_MIN;
      2:       return C_ZERO;
      default: return C_NEG1;
    endcase
  endfunction

  task automatic send_random_point();
    coord_t nxt[3];
    int     mode;
    int     span;
    int     dlt;
    mode = $urandom_range(0, 15);
    for (int i = 0; i < 3; i++) begin
      if (mode <= 2) begin
        nxt[i] = coord_t'($urandom());
      end else if (mode <= 4) begin
        nxt[i] = pick_extreme();
      end else if (mode == 5) begin
        nxt[i] = gen_pt[i];
      end else begin
        // small walk from the last point, wraps at the field edge
        span   = 1 << $urandom_range(0, 20);
        dlt    = int'($urandom_range(0, 2 * span)) - span;
        nxt[i] = coord_t'(int'(gen_pt[i]) + dlt);
      end
    end
    send_point(nxt[0], nxt[1], nxt[2], $urandom_range(0, 19) == 0);
  endtask

  initial begin
    logic [CFG_W-1:0] phase_setting[7];
    int               gap_one_in;

    phase_setting = '{2'd1, 2'd3, 2'd2, 2'd0, 2'd3, 2'd1, 2'd2};
    sb = new();
    for (int i = 0; i < 3; i++) gen_pt[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // three components from reset; first request has no restart flag
    send_point(C_MAX, C_MAX, C_MAX, 1'b0);
    send_point(C_MIN, C_MIN, C_MIN, 1'b0);
    send_point(C_ZERO, C_ZERO, C_ZERO, 1'b0);
    send_point(C_NEG1, C_NEG1, C_NEG1, 1'b0);
    send_point(C_ZERO, C_ZERO, C_ZERO, 1'b1);
    send_point(coord_t'(3 * C_ONE_UNIT), coord_t'(4 * C_ONE_UNIT), C_ZERO, 1'b0);
    send_point(coord_t'(3 * C_ONE_UNIT), coord_t'(4 * C_ONE_UNIT), C_ZERO, 1'b0);
    send_point(C_MIN, C_MAX, C_MIN, 1'b0);

    // two components: third coordinate is still stored
    apply_setting(2'd2);
    send_point(C_MAX, C_MIN, coord_t'(12345), 1'b0);
    send_point(C_MIN, C_MAX, coord_t'(-5), 1'b0);
    send_point(C_ZERO, C_ZERO, C_MAX, 1'b1);

    // one component: signed steps, total may go negative
    apply_setting(2'd1);
    send_point(coord_t'(100), C_MAX, C_MIN, 1'b0);
    send_point(coord_t'(-100), C_MIN, C_MAX, 1'b0);
    send_point(C_MIN, C_ZERO, C_ZERO, 1'b0);
    send_point(C_MAX, C_NEG1, C_NEG1, 1'b0);
    send_point(C_MIN, C_ZERO, C_ZERO, 1'b0);
    send_point(C_NEG1, C_MAX, C_MAX, 1'b1);

    // zero components behaves like one
    apply_setting(2'd0);
    send_point(coord_t'(5000), C_MAX, C_MAX, 1'b0);
    send_point(coord_t'(-5000), C_MIN, C_MIN, 1'b0);
    send_point(C_MAX, C_ZERO, C_ZERO, 1'b0);

    for (int p = 0; p < 7; p++) begin
      apply_setting(phase_setting[p]);
      if (p == 6) calm = 1'b1;
      case ($urandom_range(0, 2))
        0:       gap_one_in = 0;
        1:       gap_one_in = 3;
        default: gap_one_in = 8;
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (!calm && gap_one_in != 0 && $urandom_range(1, gap_one_in) == 1) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end
        send_random_point();
      end
    end

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
